// File: hdl/x2dp_pkg.sv
// ----------------------------------------------------------------------------
// x2dp_pkg: shared codes for the 2D XOR parity erasure codec
// Command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package x2dp_pkg;
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_MARK  = 3'd1;
  localparam logic [2:0] CMD_GEN   = 3'd2;
  localparam logic [2:0] CMD_REC   = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [0:0] REG_DATA_DIM    = 1'd0;
  localparam logic [0:0] REG_BLOCK_WORDS = 1'd1;

  typedef logic [63:0] word_t;
endpackage

// File: hdl/xor_2d_parity_erasure_codec.sv
// ----------------------------------------------------------------------------
// xor_2d_parity_erasure_codec: two-dimensional XOR parity erasure codec
// Holds a (D+1)x(D+1) grid of blocks of 64-bit words plus an erasure map, and
// generates row/column parity or rebuilds erased blocks from it.
// ----------------------------------------------------------------------------
// Sequence: writes, marks, reads and unused commands pass through accept, memory
// access, result load and result hand-off, and wait in hand-off while the output stalls.
// Generate and recover run on one shared XOR accumulator fed by the single read
// port of the block memory. A recover also counts the erasures of each line in
// every sweep and ends with one final sweep that rebuilds nothing. The input is
// stalled until the result transaction has been taken.
// The block memory has no reset; the erasure map resets to zero at once.
module xor_2d_parity_erasure_codec #(
  parameter int MAX_DIM         = 8,
  parameter int MAX_BLOCK_WORDS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic [8:0]  in_word_index,
  input  logic [63:0] in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_read_data,
  output logic        out_still_erased,
  output logic        out_status
);
  localparam int SIDE  = MAX_DIM + 1;
  localparam int CW    = $clog2(SIDE + 1);          // holds 0..SIDE
  localparam int WW    = $clog2(MAX_BLOCK_WORDS + 1);
  localparam int WIW   = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
  localparam int BW    = (SIDE * SIDE > 1) ? $clog2(SIDE * SIDE) : 1;
  localparam int DEPTH = SIDE * SIDE * MAX_BLOCK_WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;   // simple command memory access
  localparam logic [3:0] S_DONE  = 4'd2;   // result held
  localparam logic [3:0] S_GRD   = 4'd3;   // line XOR: issue reads
  localparam logic [3:0] S_GWR   = 4'd4;   // line XOR: write result
  localparam logic [3:0] S_CNT   = 4'd5;   // recover: count a line
  localparam logic [3:0] S_RSTRT = 4'd6;   // recover: sweep end
  localparam logic [3:0] S_RESP  = 4'd7;   // load result

  // ---- configuration ----
  logic [3:0] dim_r;
  logic [9:0] bw_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 4'd8;
      bw_r  <= 10'd512;
    end else if (cfg_valid) begin
      case (cfg_index)
        x2dp_pkg::REG_DATA_DIM:    dim_r <= cfg_data[3:0];
        x2dp_pkg::REG_BLOCK_WORDS: bw_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] d_eff;
  logic [WW-1:0] nw_eff;
  always_comb begin
    if (dim_r == 4'd0) d_eff = CW'(1);
    else if (32'(dim_r) > MAX_DIM) d_eff = CW'(MAX_DIM);
    else d_eff = CW'(dim_r);
    if (bw_r == 10'd0) nw_eff = WW'(1);
    else if (32'(bw_r) > MAX_BLOCK_WORDS) nw_eff = WW'(MAX_BLOCK_WORDS);
    else nw_eff = WW'(bw_r);
  end

  // ---- storage ----
  x2dp_pkg::word_t mem [DEPTH];
  logic [SIDE-1:0] emap_r [SIDE];
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  x2dp_pkg::word_t wdata, rdata_r;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r,
                                            input logic [CW-1:0] c,
                                            input logic [WIW-1:0] w);
    logic [BW-1:0] blk;
    blk = BW'(32'(r) * SIDE + 32'(c));
    return AW'(32'(blk) * MAX_BLOCK_WORDS + 32'(w));
  endfunction

  // ---- sequencer state ----
  logic [3:0]     st_r, st_nxt;
  logic [2:0]     cmd_r;
  logic [3:0]     row_r, col_r;
  logic [8:0]     wi_r;
  x2dp_pkg::word_t data_r;
  // line job: target (tr,tc); along row or column; k walks the line
  logic           grow_r;        // 1 = line is a row
  logic           gen_r;         // 1 = generate, 0 = recover
  logic           phase_r;       // generate: 0 rows, 1 columns; recover same
  logic [CW-1:0]  li_r;          // line index
  logic [CW-1:0]  tr_r, tc_r;
  logic [CW-1:0]  k_r;           // read issue position (0..lim+2)
  logic           kv_r;          // previous cycle issued a useful read
  logic [WIW-1:0] w_r;
  x2dp_pkg::word_t acc_r;
  logic           again_r, many_r;
  logic [CW-1:0]  cnt_r, pos_r, ci_r; // erasure count / last position / scan
  x2dp_pkg::word_t o_data_r;
  logic           o_er_r, o_st_r;

  logic in_grid;
  assign in_grid = (32'(row_r) <= 32'(d_eff)) && (32'(col_r) <= 32'(d_eff));
  logic word_ok;
  assign word_ok = 32'(wi_r) < MAX_BLOCK_WORDS;

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  assign out_read_data    = o_data_r;
  assign out_still_erased = o_er_r;
  assign out_status       = o_st_r;

  // line element positions
  logic [CW-1:0] lim;          // last k is d (recover) or d-1 (generate)
  logic          kskip;        // k equals the rebuilt position
  logic [CW-1:0] rr, rc;
  always_comb begin
    lim   = gen_r ? d_eff - CW'(1) : d_eff;
    kskip = !gen_r && (grow_r ? (k_r == tc_r) : (k_r == tr_r));
    rr = grow_r ? tr_r : k_r;
    rc = grow_r ? k_r : tc_r;
  end

  logic bit_here;
  assign bit_here = phase_r ? emap_r[ci_r][li_r] : emap_r[li_r][ci_r];

  always_comb begin
    we    = 1'b0;
    waddr = addr_of(tr_r, tc_r, w_r);
    wdata = acc_r;
    raddr = addr_of(rr, rc, w_r);
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_ACC;
      S_ACC: begin
        waddr = addr_of(CW'(row_r), CW'(col_r), WIW'(wi_r));
        raddr = waddr;
        wdata = data_r;
        we = (cmd_r == x2dp_pkg::CMD_WRITE) && in_grid && word_ok;
        case (cmd_r)
          x2dp_pkg::CMD_GEN: st_nxt = S_GRD;
          x2dp_pkg::CMD_REC: st_nxt = S_CNT;
          x2dp_pkg::CMD_READ: st_nxt = S_RESP;
          default: st_nxt = S_RESP;
        endcase
      end
      S_GRD: if (k_r == lim + CW'(1)) st_nxt = S_GWR;
      S_GWR: begin
        we = 1'b1;
        st_nxt = S_GRD;
        // last word of the line: pick the next job
        if (32'(w_r) + 1 >= 32'(nw_eff)) begin
          if (gen_r) begin
            if (phase_r && !(li_r + CW'(1) < d_eff)) st_nxt = S_RESP;
          end else begin
            st_nxt = (li_r + CW'(1) < d_eff || !phase_r) ? S_CNT : S_RSTRT;
          end
        end
      end
      S_CNT: begin
        if (ci_r > d_eff) begin
          if (cnt_r == CW'(1)) st_nxt = S_GRD;
          else if (phase_r && !(li_r + CW'(1) < d_eff)) st_nxt = S_RSTRT;
        end
      end
      S_RSTRT: st_nxt = again_r ? S_CNT : S_RESP;
      S_RESP: st_nxt = S_DONE;
      S_DONE: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int i = 0; i < SIDE; i++) emap_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: if (in_valid) begin
          cmd_r <= in_command; row_r <= in_row; col_r <= in_col;
          wi_r <= in_word_index; data_r <= in_data;
        end
        S_ACC: begin
          o_data_r <= '0; o_er_r <= 1'b0; o_st_r <= 1'b0;
          if (cmd_r == x2dp_pkg::CMD_MARK && in_grid)
            emap_r[row_r[CW-1:0]][col_r[CW-1:0]] <= 1'b1;
          if (cmd_r == x2dp_pkg::CMD_GEN) begin
            gen_r <= 1'b1; phase_r <= 1'b0; li_r <= '0; grow_r <= 1'b1;
            tr_r <= '0; tc_r <= d_eff; k_r <= '0; kv_r <= 1'b0;
            w_r <= '0; acc_r <= '0;
          end
          if (cmd_r == x2dp_pkg::CMD_REC) begin
            gen_r <= 1'b0; phase_r <= 1'b0; li_r <= '0; ci_r <= '0;
            cnt_r <= '0; again_r <= 1'b0; many_r <= 1'b0;
          end
        end
        S_GRD: begin
          if (kv_r) acc_r <= acc_r ^ rdata_r;
          kv_r <= (k_r <= lim) && !kskip;
          if (k_r <= lim) k_r <= k_r + CW'(1);
          else k_r <= lim + CW'(2);
        end
        S_GWR: begin
          acc_r <= '0; k_r <= '0; kv_r <= 1'b0;
          if (32'(w_r) + 1 < 32'(nw_eff)) begin
            w_r <= w_r + WIW'(1);
          end else begin
            w_r <= '0;
            if (gen_r) begin
              if (li_r + CW'(1) < d_eff) begin
                li_r <= li_r + CW'(1);
                if (!phase_r) tr_r <= li_r + CW'(1);
                else tc_r <= li_r + CW'(1);
              end else if (!phase_r) begin
                phase_r <= 1'b0 | 1'b1; li_r <= '0; grow_r <= 1'b0;
                tr_r <= d_eff; tc_r <= '0;
              end
            end else begin
              emap_r[tr_r][tc_r] <= 1'b0;
              again_r <= 1'b1;
              ci_r <= '0; cnt_r <= '0;
              if (li_r + CW'(1) < d_eff) li_r <= li_r + CW'(1);
              else if (!phase_r) begin phase_r <= 1'b1; li_r <= '0; end
              else li_r <= d_eff;
            end
          end
        end
        S_CNT: begin
          if (ci_r <= d_eff) begin
            if (bit_here) begin
              cnt_r <= (cnt_r == CW'(2)) ? cnt_r : cnt_r + CW'(1);
              pos_r <= ci_r;
            end
            ci_r <= ci_r + CW'(1);
          end else begin
            ci_r <= '0; cnt_r <= '0;
            if (cnt_r == CW'(1)) begin
              grow_r <= !phase_r;
              tr_r <= phase_r ? pos_r : li_r;
              tc_r <= phase_r ? li_r : pos_r;
              k_r <= '0; kv_r <= 1'b0; w_r <= '0; acc_r <= '0;
            end else begin
              if (cnt_r != '0) many_r <= 1'b1;
              if (li_r + CW'(1) < d_eff) li_r <= li_r + CW'(1);
              else if (!phase_r) begin phase_r <= 1'b1; li_r <= '0; end
            end
          end
        end
        S_RSTRT: begin
          if (again_r) begin
            again_r <= 1'b0; many_r <= 1'b0; phase_r <= 1'b0;
            li_r <= '0; ci_r <= '0; cnt_r <= '0;
          end
        end
        S_RESP: begin
          if (cmd_r == x2dp_pkg::CMD_REC) o_st_r <= many_r;
          if (cmd_r == x2dp_pkg::CMD_READ && in_grid) begin
            if (word_ok) o_data_r <= rdata_r;
            o_er_r <= emap_r[row_r[CW-1:0]][col_r[CW-1:0]];
          end
        end
        default: ;
      endcase
    end
  end
endmodule
